/* hdl/u8u16_pkg.sv */
// shared types and constants for the utf-8 to utf-16 decoder
`timescale 1ns / 1ps

package u8u16_pkg;

  // field widths of the byte, code unit and config words
  localparam int BYTE_W = 8;
  localparam int UNIT_W = 16;
  localparam int CFG_W  = 13;

  // reset value of the unit limit register
  localparam logic [CFG_W-1:0] LIMIT_RESET = 13'd4096;

  // queue between the decode front and the output back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // byte classification masks
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE   = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
  localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;

  // continuation bytes dropped after an unusable lead
  localparam logic [1:0] SKIP_COUNT = 2'd3;

  // decode phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TWO,
    PH_THREE_A,
    PH_THREE_B,
    PH_SKIP
  } phase_t;

  // one result entry
  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              last;
  } unit_t;

  // up to two entries pushed per accepted byte
  typedef struct packed {
    logic [1:0] count;
    unit_t      first;
    unit_t      second;
  } push_t;

endpackage

/* hdl/u8u16_if.sv */
// byte and code unit channel interfaces
`timescale 1ns / 1ps

interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last;

  modport source (output valid, output code_unit, output last, input ready);
  modport sink (input valid, input code_unit, input last, output ready);
endinterface

/* hdl/utf8_to_utf16_bmp_decoder.sv */
// top level of the utf-8 to utf-16 basic plane decoder
//
//  channel | direction | payload               | handshake
//  bytes   | in        | in_byte[7:0]          | valid / ready
//  units   | out       | code_unit[15:0], last | valid / ready
//  cfg     | in        | cfg_data[12:0]        | cfg_we, no wait
//
// one byte is taken per clock while the four-entry unit queue has room
// for two units; a byte that yields two units pushes both at once.
// units leave through a registered output, one per clock when the sink
// is ready, so one unit per cycle out sets the sustained figure.
// a stalled sink fills the queue and then holds ready low on bytes.
// rst is synchronous and clears decode state, queue and output valid.
`timescale 1ns / 1ps

module utf8_to_utf16_bmp_decoder #(
  parameter int MAX_UNITS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [u8u16_pkg::CFG_W-1:0] cfg_data,
  u8u16_byte_if.sink                  bytes,
  u8u16_unit_if.source                units
);

  logic [u8u16_pkg::CFG_W-1:0] max_out_units;
  u8u16_pkg::push_t push;
  u8u16_pkg::unit_t head;
  logic room, nonempty, pop;

  // unit limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_units <= u8u16_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      max_out_units <= cfg_data;
    end
  end

  u8u16_front #(
    .MAX_UNITS (MAX_UNITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .max_out_units (max_out_units),
    .room          (room),
    .bytes         (bytes),
    .push          (push)
  );

  u8u16_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .room     (room),
    .nonempty (nonempty),
    .head     (head)
  );

  u8u16_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .units    (units)
  );

endmodule

/* hdl/u8u16_front.sv */
// decode front: accepts bytes, tracks sequence state, produces code units
`timescale 1ns / 1ps

module u8u16_front #(
  parameter int MAX_UNITS = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [u8u16_pkg::CFG_W-1:0] max_out_units,
  input  logic                     room,
  u8u16_byte_if.sink               bytes,
  output u8u16_pkg::push_t         push
);

  localparam int UW = $clog2(MAX_UNITS + 1);
  localparam int CW = ((UW > u8u16_pkg::CFG_W) ? UW : u8u16_pkg::CFG_W) + 1;

  u8u16_pkg::phase_t phase, phase_next;
  logic [u8u16_pkg::UNIT_W-1:0] partial, partial_next;
  logic [UW-1:0] units, units_next;
  logic [1:0] skip_left, skip_left_next;
  logic halted, halted_next;

  logic [u8u16_pkg::BYTE_W-1:0] b;
  logic take;
  logic is_zero, cont, mid, ascii, lead2, lead3;
  logic [CW-1:0] limit_raw, eff, units_ext;
  logic hit0, hit1, hit2;
  logic [u8u16_pkg::UNIT_W-1:0] done_val, lead2_val, lead3_val, mid3_val;

  assign bytes.ready = room;
  assign take = bytes.valid && room;
  assign b = bytes.in_byte;

  // byte classification
  assign is_zero = (b == '0);
  assign cont    = ((b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_CODE);
  assign ascii   = (b < u8u16_pkg::ASCII_LIMIT);
  assign lead2   = ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE);
  assign lead3   = ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE);
  assign mid     = (phase inside {u8u16_pkg::PH_TWO, u8u16_pkg::PH_THREE_A,
                                  u8u16_pkg::PH_THREE_B});

  // assembled values
  assign done_val  = partial | {8'd0, b & u8u16_pkg::CONT_BITS};
  assign lead2_val = {3'd0, 5'(b & u8u16_pkg::LEAD2_BITS), 8'd0} >> 2;
  assign lead3_val = {4'(b & u8u16_pkg::LEAD3_BITS), 12'd0};
  assign mid3_val  = partial | {4'd0, 6'(b & u8u16_pkg::CONT_BITS), 6'd0};

  // effective limit, clamped to 1..MAX_UNITS
  assign limit_raw = CW'(max_out_units);
  always_comb begin
    if (limit_raw == '0) begin
      eff = CW'(1);
    end else if (limit_raw > CW'(MAX_UNITS)) begin
      eff = CW'(MAX_UNITS);
    end else begin
      eff = limit_raw;
    end
  end

  // limit checks after zero, one and two more units
  assign units_ext = CW'(units);
  assign hit0 = (units_ext + CW'(1)) >= eff;
  assign hit1 = (units_ext + CW'(2)) >= eff;
  assign hit2 = (units_ext + CW'(3)) >= eff;

  // next state
  always_comb begin
    phase_next     = phase;
    partial_next   = partial;
    units_next     = units;
    skip_left_next = skip_left;
    halted_next    = halted;
    if (is_zero) begin
      phase_next     = u8u16_pkg::PH_IDLE;
      partial_next   = '0;
      units_next     = '0;
      skip_left_next = '0;
      halted_next    = 1'b0;
    end else if (!halted) begin
      if ((phase == u8u16_pkg::PH_THREE_A) && cont) begin
        partial_next = mid3_val;
        phase_next   = u8u16_pkg::PH_THREE_B;
      end else if (((phase == u8u16_pkg::PH_TWO) || (phase == u8u16_pkg::PH_THREE_B))
                   && cont) begin
        units_next   = units + UW'(1);
        halted_next  = hit1;
        phase_next   = u8u16_pkg::PH_IDLE;
        partial_next = '0;
      end else if ((phase == u8u16_pkg::PH_SKIP) && cont && (skip_left != 2'd0)) begin
        skip_left_next = skip_left - 2'd1;
        if (skip_left == 2'd1) begin
          phase_next = u8u16_pkg::PH_IDLE;
        end
      end else begin
        // byte starts anew; a broken sequence first emits its partial unit
        phase_next     = u8u16_pkg::PH_IDLE;
        skip_left_next = '0;
        if (mid) begin
          partial_next = '0;
          units_next   = units + UW'(1);
          if (hit1) begin
            halted_next = 1'b1;
          end else if (ascii) begin
            units_next  = units + UW'(2);
            halted_next = hit2;
          end else if (lead2) begin
            partial_next = lead2_val;
            phase_next   = u8u16_pkg::PH_TWO;
          end else if (lead3) begin
            partial_next = lead3_val;
            phase_next   = u8u16_pkg::PH_THREE_A;
          end else begin
            phase_next     = u8u16_pkg::PH_SKIP;
            skip_left_next = u8u16_pkg::SKIP_COUNT;
          end
        end else begin
          if (hit0) begin
            halted_next = 1'b1;
          end else if (ascii) begin
            units_next  = units + UW'(1);
            halted_next = hit1;
          end else if (lead2) begin
            partial_next = lead2_val;
            phase_next   = u8u16_pkg::PH_TWO;
          end else if (lead3) begin
            partial_next = lead3_val;
            phase_next   = u8u16_pkg::PH_THREE_A;
          end else begin
            phase_next     = u8u16_pkg::PH_SKIP;
            skip_left_next = u8u16_pkg::SKIP_COUNT;
          end
        end
      end
    end
  end

  // units pushed to the queue
  always_comb begin
    push.count  = 2'd0;
    push.first  = '{code_unit: '0, last: 1'b0};
    push.second = '{code_unit: '0, last: 1'b0};
    if (take) begin
      if (is_zero) begin
        if (!halted && mid) begin
          push.count  = 2'd2;
          push.first  = '{code_unit: partial, last: 1'b0};
          push.second = '{code_unit: '0, last: 1'b1};
        end else begin
          push.count = 2'd1;
          push.first = '{code_unit: '0, last: 1'b1};
        end
      end else if (!halted) begin
        if ((phase == u8u16_pkg::PH_THREE_A) && cont) begin
          push.count = 2'd0;
        end else if (((phase == u8u16_pkg::PH_TWO) || (phase == u8u16_pkg::PH_THREE_B))
                     && cont) begin
          push.count = 2'd1;
          push.first = '{code_unit: done_val, last: 1'b0};
        end else if ((phase == u8u16_pkg::PH_SKIP) && cont && (skip_left != 2'd0)) begin
          push.count = 2'd0;
        end else if (mid) begin
          push.count = 2'd1;
          push.first = '{code_unit: partial, last: 1'b0};
          if (!hit1 && ascii) begin
            push.count  = 2'd2;
            push.second = '{code_unit: {8'd0, b}, last: 1'b0};
          end
        end else if (!hit0 && ascii) begin
          push.count = 2'd1;
          push.first = '{code_unit: {8'd0, b}, last: 1'b0};
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= u8u16_pkg::PH_IDLE;
      partial   <= '0;
      units     <= '0;
      skip_left <= '0;
      halted    <= 1'b0;
    end else if (take) begin
      phase     <= phase_next;
      partial   <= partial_next;
      units     <= units_next;
      skip_left <= skip_left_next;
      halted    <= halted_next;
    end
  end

endmodule

/* hdl/u8u16_queue.sv */
// short queue of code units between the front and the back
`timescale 1ns / 1ps

module u8u16_queue (
  input  logic             clk,
  input  logic             rst,
  input  u8u16_pkg::push_t push,
  input  logic             pop,
  output logic             room,
  output logic             nonempty,
  output u8u16_pkg::unit_t head
);

  localparam int AW = u8u16_pkg::QUEUE_AW;

  u8u16_pkg::unit_t entries [u8u16_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] fill, fill_next;

  // room for a two-unit request
  assign room     = (fill <= (AW+1)'(u8u16_pkg::QUEUE_DEPTH - 2));
  assign nonempty = (fill != '0);
  assign head     = entries[rd_ptr];

  assign fill_next = fill + (AW+1)'(push.count) - (AW+1)'(pop);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      fill <= fill_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + AW'(1)] <= push.second;
    end
  end

endmodule

/* hdl/u8u16_back.sv */
// output back: registers one code unit at a time toward the sink
`timescale 1ns / 1ps

module u8u16_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             nonempty,
  input  u8u16_pkg::unit_t head,
  output logic             pop,
  u8u16_unit_if.source     units
);

  logic             valid;
  u8u16_pkg::unit_t data;

  // load when the output register is free or being taken
  assign pop = nonempty && (!valid || units.ready);

  assign units.valid     = valid;
  assign units.code_unit = data.code_unit;
  assign units.last      = data.last;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (units.ready) begin
      valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      data <= head;
    end
  end

endmodule
